@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the scheduler core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define DPS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("scheduler assertion failed");

// Checks that a condition is followed by another one in the next cycle.
`define DPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("scheduler assertion failed");

`endif

@@ rtl/core/dps_pkg.sv @@
// Types and constants shared by the dynamic priority scheduler.
package dps_pkg;

	localparam int MAX_PROCS = 16;
	localparam int IDX_W = $clog2(MAX_PROCS);
	localparam int CNT_W = $clog2(MAX_PROCS + 1);
	localparam int ALU_W = 17;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [7:0] QUANTUM_RESET = 8'd2;
	localparam logic [7:0] PRIO_MIN = 8'h80;

	typedef struct packed {
		logic [7:0]  name;
		logic [15:0] time_left;
		logic [7:0]  prio;
	} entry_t;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  name;
		logic [15:0] time_left;
		logic [7:0]  prio;
	} item_t;

	typedef struct packed {
		logic [7:0]  name;
		logic [15:0] time_left;
		logic [7:0]  prio;
		logic        finished;
		logic        idle;
		logic        full_error;
	} result_t;

endpackage

@@ rtl/core/dps_alu.sv @@
// Shared subtractor used for priority compares and quantum deduction.
module dps_alu
	import dps_pkg::*;
(
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	output logic [ALU_W-1:0] diff,
	output logic             neg,
	output logic             zero
);

	assign diff = a - b;
	assign neg  = diff[ALU_W-1];
	assign zero = (diff == '0);

endmodule

@@ rtl/core/dps_core.sv @@
// Queue storage and sequencer that scans, selects and compacts the ready queue.
module dps_core
	import dps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] quantum,
	input  logic       in_valid,
	output logic       in_stall,
	input  item_t      item,
	output logic       res_valid,
	input  logic       res_take,
	output result_t    res
);
	`include "assert_macros.svh"

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SHIFT,
		ST_TAIL,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] di_q;
	logic [IDX_W-1:0] sk_q;
	logic [IDX_W-1:0] best_idx_q;
	entry_t           best_q;
	entry_t           requeue_entry_q;
	logic             requeue_q;
	result_t          res_q;

	entry_t           mem [MAX_PROCS];
	entry_t           rdata_q;
	logic [IDX_W-1:0] raddr;
	logic             we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata;

	logic [ALU_W-1:0] alu_a;
	logic [ALU_W-1:0] alu_b;
	logic [ALU_W-1:0] alu_diff;
	logic             alu_neg;
	logic             alu_zero;

	logic [CNT_W-1:0] cnt_m1;
	logic             accept;
	logic             full;
	logic [7:0]       prio_dec;

	assign cnt_m1   = count_q - CNT_W'(1);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign full     = (count_q == CNT_W'(MAX_PROCS));
	assign in_stall = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_EMIT);
	assign res      = res_q;
	assign prio_dec = (best_q.prio == PRIO_MIN) ? best_q.prio : best_q.prio - 8'd1;

	always_comb begin
		alu_a = {{(ALU_W-8){best_q.prio[7]}}, best_q.prio};
		alu_b = {{(ALU_W-8){rdata_q.prio[7]}}, rdata_q.prio};
		if (state_q == ST_DECIDE) begin
			alu_a = {{(ALU_W-16){1'b0}}, best_q.time_left};
			alu_b = {{(ALU_W-8){1'b0}}, quantum};
		end
	end

	dps_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.neg  (alu_neg),
		.zero (alu_zero)
	);

	always_comb begin
		case (state_q)
			ST_SCAN:   raddr = di_q + IDX_W'(1);
			ST_DECIDE: raddr = best_idx_q + IDX_W'(1);
			ST_SHIFT:  raddr = sk_q + IDX_W'(2);
			default:   raddr = '0;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = count_q[IDX_W-1:0];
		wdata = '{name: item.name, time_left: item.time_left, prio: item.prio};
		case (state_q)
			ST_IDLE: begin
				we = accept && (item.opcode == OP_LOAD) && !full;
			end
			ST_SHIFT: begin
				we    = 1'b1;
				waddr = sk_q;
				wdata = rdata_q;
			end
			ST_TAIL: begin
				we    = requeue_q;
				waddr = cnt_m1[IDX_W-1:0];
				wdata = requeue_entry_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			count_q         <= '0;
			di_q            <= '0;
			sk_q            <= '0;
			best_idx_q      <= '0;
			best_q          <= '0;
			requeue_entry_q <= '0;
			requeue_q       <= 1'b0;
			res_q           <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.opcode == OP_LOAD) begin
							res_q <= '{name: '0, time_left: '0, prio: '0,
								finished: 1'b0, idle: 1'b0, full_error: full};
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= ST_EMIT;
						end else if (count_q == '0) begin
							res_q <= '{name: '0, time_left: '0, prio: '0,
								finished: 1'b0, idle: 1'b1, full_error: 1'b0};
							state_q <= ST_EMIT;
						end else begin
							di_q    <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if ((di_q == '0) || alu_neg) begin
						best_q     <= rdata_q;
						best_idx_q <= di_q;
					end
					di_q <= di_q + IDX_W'(1);
					if (CNT_W'(di_q) == cnt_m1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					requeue_q       <= !alu_neg && !alu_zero;
					requeue_entry_q <= '{name: best_q.name, time_left: alu_diff[15:0],
						prio: prio_dec};
					if (!alu_neg && !alu_zero) begin
						res_q <= '{name: best_q.name, time_left: alu_diff[15:0],
							prio: prio_dec, finished: 1'b0, idle: 1'b0,
							full_error: 1'b0};
					end else begin
						res_q <= '{name: best_q.name, time_left: '0,
							prio: best_q.prio, finished: 1'b1, idle: 1'b0,
							full_error: 1'b0};
					end
					sk_q <= best_idx_q;
					if ((CNT_W'(best_idx_q) + CNT_W'(1)) < count_q) begin
						state_q <= ST_SHIFT;
					end else begin
						state_q <= ST_TAIL;
					end
				end
				ST_SHIFT: begin
					sk_q <= sk_q + IDX_W'(1);
					if ((CNT_W'(sk_q) + CNT_W'(2)) >= count_q) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					if (!requeue_q) begin
						count_q <= cnt_m1;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`DPS_ASSERT(a_count_bound, (count_q <= CNT_W'(MAX_PROCS)))
	`DPS_ASSERT(a_count_step, ((count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1))))
	`DPS_ASSERT_NEXT(a_empty_tick, accept && (item.opcode == OP_TICK) && (count_q == '0), (state_q == ST_EMIT) && res_q.idle)
	`DPS_ASSERT(a_shift_range, ((state_q != ST_SHIFT) || ((CNT_W'(sk_q) + CNT_W'(1)) < count_q)))

endmodule

@@ rtl/core/dynamic_priority_scheduler_top.sv @@
// Load, or tick on an empty queue: the result goes to the core result register, then to the output register.
// Tick with N queued entries: the core scans the queue memory one entry per cycle, decides,
// compacts the entries behind the selected one one entry per cycle, writes the tail and emits.
// One item is in work at a time; a finished result waits in the output register.
// Reset clears the entry count and sets the quantum to 2; queue storage is not cleared.
// Top level of the dynamic priority scheduler: configuration and output register.
module dynamic_priority_scheduler_top
	import dps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              quantum_wr_en,
	input  logic [7:0]        quantum_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              opcode,
	input  logic [7:0]        proc_name,
	input  logic [15:0]       proc_time,
	input  logic signed [7:0] proc_priority,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_name,
	output logic [15:0]       out_time_left,
	output logic signed [7:0] out_priority,
	output logic              finished,
	output logic              idle,
	output logic              full_error
);

	logic       [7:0] quantum_q;
	item_t            item;
	logic             res_valid;
	logic             res_take;
	result_t          res;
	logic             out_valid_q;
	result_t          out_res_q;
	logic             out_free;

	assign item = '{opcode: opcode, name: proc_name, time_left: proc_time,
		prio: proc_priority};

	assign out_free = !out_valid_q || !out_stall;
	assign res_take = res_valid && out_free;

	dps_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.quantum   (quantum_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.item      (item),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q   <= QUANTUM_RESET;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else begin
			if (quantum_wr_en) begin
				quantum_q <= quantum_wr_data;
			end
			if (out_free) begin
				out_valid_q <= res_valid;
				if (res_valid) begin
					out_res_q <= res;
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_name      = out_res_q.name;
	assign out_time_left = out_res_q.time_left;
	assign out_priority  = out_res_q.prio;
	assign finished      = out_res_q.finished;
	assign idle          = out_res_q.idle;
	assign full_error    = out_res_q.full_error;

endmodule
